// File: rtl/sdspi_pkg.sv
// types and constants shared by the sd card spi sequencer
package sdspi_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 512;

    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;
    localparam logic [1:0] FUNC_DELAY = 2'd3;

    localparam logic [1:0] ACT_XCHG  = 2'd0;
    localparam logic [1:0] ACT_DELAY = 2'd1;
    localparam logic [1:0] ACT_DONE  = 2'd2;
    localparam logic [1:0] ACT_IDLE  = 2'd3;

    localparam logic [2:0] REG_PWR_DELAY   = 3'd0;
    localparam logic [2:0] REG_RETRY_DELAY = 3'd1;
    localparam logic [2:0] REG_POLL_LIMIT  = 3'd2;
    localparam logic [2:0] REG_ATTEMPTS    = 3'd3;
    localparam logic [2:0] REG_TOKEN_LIMIT = 3'd4;

    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] TOKEN_DATA = 8'hFE;
    localparam logic [7:0] CMD_BASE   = 8'h40;
    localparam logic [7:0] CRC_CMD0   = 8'h95;
    localparam logic [7:0] CRC_CMD8   = 8'h87;
    localparam logic [7:0] CRC_OTHER  = 8'h01;
    localparam logic [31:0] ARG_CMD8  = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS   = 32'h4000_0000;
    localparam logic [31:0] ARG_BLKLEN = 32'd512;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] block_number;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  tx_byte;
        logic        cs_active;
        logic        slow_clock;
        logic [15:0] delay_count;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [8:0]  data_index;
        logic        success;
        logic [7:0]  last_r1;
    } t_out_item;

    typedef struct packed {
        logic [15:0] power_up_delay;
        logic [15:0] retry_delay;
        logic [7:0]  response_poll_limit;
        logic [11:0] init_attempt_limit;
        logic [19:0] token_wait_limit;
    } t_cfg;

    typedef enum logic [23:0] {
        PH_IDLE           = 24'd1 << 0,
        PH_PWR_DELAY      = 24'd1 << 1,
        PH_DUMMY          = 24'd1 << 2,
        PH_CMD0           = 24'd1 << 3,
        PH_CMD0_TAIL      = 24'd1 << 4,
        PH_CMD8           = 24'd1 << 5,
        PH_CMD8_EXTRA     = 24'd1 << 6,
        PH_CMD8_TAIL      = 24'd1 << 7,
        PH_CMD55          = 24'd1 << 8,
        PH_CMD55_TAIL     = 24'd1 << 9,
        PH_CMD41          = 24'd1 << 10,
        PH_CMD41_TAIL     = 24'd1 << 11,
        PH_RETRY_DELAY    = 24'd1 << 12,
        PH_CMD58          = 24'd1 << 13,
        PH_OCR            = 24'd1 << 14,
        PH_CMD58_TAIL     = 24'd1 << 15,
        PH_CMD16          = 24'd1 << 16,
        PH_CMD16_TAIL     = 24'd1 << 17,
        PH_CMD17          = 24'd1 << 18,
        PH_TOKEN          = 24'd1 << 19,
        PH_DATA           = 24'd1 << 20,
        PH_CRC            = 24'd1 << 21,
        PH_READ_TAIL      = 24'd1 << 22,
        PH_READ_FAIL_TAIL = 24'd1 << 23
    } t_phase;

endpackage

// File: rtl/sdspi_cfg_regs.sv
// configuration register file of the sd card spi sequencer
module sdspi_cfg_regs
    import sdspi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_up_delay      <= 16'd32000;
            r_cfg.retry_delay         <= 16'd16000;
            r_cfg.response_poll_limit <= 8'd64;
            r_cfg.init_attempt_limit  <= 12'd2000;
            r_cfg.token_wait_limit    <= 20'd400000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PWR_DELAY:   r_cfg.power_up_delay      <= i_cfg_data[15:0];
                REG_RETRY_DELAY: r_cfg.retry_delay         <= i_cfg_data[15:0];
                REG_POLL_LIMIT:  r_cfg.response_poll_limit <= i_cfg_data[7:0];
                REG_ATTEMPTS:    r_cfg.init_attempt_limit  <= i_cfg_data[11:0];
                REG_TOKEN_LIMIT: r_cfg.token_wait_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// File: rtl/sd_spi_init_and_block_read.sv
// sd card spi mode init and single block read sequencer, top level
// an accepted item's result is in the output register in the cycle after it is taken
// throughput: one item per cycle while o_stall is low; the phase register and its next-state logic set it
// the output register holds a result under stall; the next item is taken only
// if the output slot is free or drains in the same cycle
// reset: synchronous active low, phase idle, config registers at their defaults
module sd_spi_init_and_block_read
    import sdspi_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    localparam int unsigned BC_W = $clog2(BLOCK_BYTES) + 1;

    localparam logic [1:0] RES_ON     = 2'd0;
    localparam logic [1:0] RES_OK     = 2'd1;
    localparam logic [1:0] RES_FAIL   = 2'd2;
    localparam logic [1:0] RES_IGNORE = 2'd3;

    t_cfg cfg;
    sdspi_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    t_phase r_phase, n_phase;
    logic r_busy_op, n_busy_op;
    logic [19:0] r_poll, n_poll;
    logic [11:0] r_attempt, n_attempt;
    logic [3:0] r_frame, n_frame;
    logic [7:0] r_resp, n_resp;
    logic r_hc, n_hc;
    logic [7:0] r_read_resp, n_read_resp;
    logic [31:0] r_arg, n_arg;
    logic [BC_W-1:0] r_bc, n_bc;
    logic r_ovalid;
    t_out_item r_out, n_out;

    logic accept;
    assign o_stall = r_ovalid && i_stall;
    assign accept = i_valid && !o_stall;

    logic [7:0] poll_lim;
    logic [11:0] att_lim;
    logic [19:0] tok_lim;
    assign poll_lim = (cfg.response_poll_limit == 8'd0) ? 8'd1 : cfg.response_poll_limit;
    assign att_lim = (cfg.init_attempt_limit == 12'd0) ? 12'd1 : cfg.init_attempt_limit;
    assign tok_lim = (cfg.token_wait_limit == 20'd0) ? 20'd1 : cfg.token_wait_limit;

    function automatic logic is_cmd(input t_phase p);
        return p == PH_CMD0 || p == PH_CMD8 || p == PH_CMD55 || p == PH_CMD41 ||
               p == PH_CMD58 || p == PH_CMD16 || p == PH_CMD17;
    endfunction

    function automatic logic [7:0] cmd_num(input t_phase p);
        case (p)
            PH_CMD8:  return 8'd8;
            PH_CMD55: return 8'd55;
            PH_CMD41: return 8'd41;
            PH_CMD58: return 8'd58;
            PH_CMD16: return 8'd16;
            PH_CMD17: return 8'd17;
            default:  return 8'd0;
        endcase
    endfunction

    always_comb begin
        logic [1:0] res;
        logic [7:0] rx;
        logic [7:0] r;
        logic cdone;
        logic want_ok;
        logic [31:0] blk_arg;
        n_phase = r_phase; n_busy_op = r_busy_op; n_poll = r_poll;
        n_attempt = r_attempt; n_frame = r_frame; n_resp = r_resp; n_hc = r_hc;
        n_read_resp = r_read_resp; n_arg = r_arg; n_bc = r_bc;
        n_out = '0;
        n_out.action = ACT_IDLE;
        res = RES_ON; cdone = 1'b0; r = BYTE_FF;
        rx = i_item.rx_byte;
        blk_arg = r_hc ? i_item.block_number : {i_item.block_number[22:0], 9'd0};
        want_ok = (r_phase == PH_PWR_DELAY || r_phase == PH_RETRY_DELAY)
                  ? (i_item.func == FUNC_DELAY) : (i_item.func == FUNC_RX);
        if (r_phase == PH_IDLE) begin
            if (i_item.func == FUNC_INIT) begin
                n_busy_op = 1'b0; n_phase = PH_PWR_DELAY;
            end else if (i_item.func == FUNC_READ) begin
                n_busy_op = 1'b1; n_phase = PH_CMD17; n_frame = '0; n_poll = '0;
                n_arg = blk_arg;
            end else begin
                res = RES_IGNORE;
            end
        end else if (!want_ok) begin
            res = RES_IGNORE;
        end else if (is_cmd(r_phase)) begin
            if (r_frame < 4'd7) begin
                n_frame = r_frame + 4'd1;
            end else if (rx != BYTE_FF) begin
                cdone = 1'b1; r = rx;
            end else begin
                n_poll = r_poll + 20'd1;
                if (n_poll >= {12'd0, poll_lim}) cdone = 1'b1;
            end
            if (cdone) begin
                n_resp = r;
                case (r_phase)
                    PH_CMD0: n_phase = PH_CMD0_TAIL;
                    PH_CMD8: begin
                        if (r == R1_IDLE) begin
                            n_hc = 1'b1; n_bc = '0; n_phase = PH_CMD8_EXTRA;
                        end else begin
                            n_hc = 1'b0; n_phase = PH_CMD8_TAIL;
                        end
                    end
                    PH_CMD55: n_phase = PH_CMD55_TAIL;
                    PH_CMD41: n_phase = PH_CMD41_TAIL;
                    PH_CMD58: begin
                        n_bc = '0;
                        n_phase = (r == 8'd0) ? PH_OCR : PH_CMD58_TAIL;
                    end
                    PH_CMD16: n_phase = PH_CMD16_TAIL;
                    default: begin
                        n_read_resp = r;
                        if (r != 8'd0) n_phase = PH_READ_FAIL_TAIL;
                        else begin
                            n_poll = '0; n_phase = PH_TOKEN;
                        end
                    end
                endcase
            end
        end else begin
            case (r_phase)
                PH_PWR_DELAY: begin
                    n_bc = '0; n_phase = PH_DUMMY;
                end
                PH_DUMMY: begin
                    n_bc = r_bc + 1'b1;
                    if (n_bc >= BC_W'(10)) begin
                        n_phase = PH_CMD0; n_frame = '0; n_poll = '0; n_arg = '0;
                    end
                end
                PH_CMD0_TAIL: begin
                    if (r_resp != R1_IDLE) res = RES_FAIL;
                    else begin
                        n_phase = PH_CMD8; n_frame = '0; n_poll = '0; n_arg = ARG_CMD8;
                    end
                end
                PH_CMD8_EXTRA: begin
                    n_bc = r_bc + 1'b1;
                    if (n_bc >= BC_W'(4)) n_phase = PH_CMD8_TAIL;
                end
                PH_CMD8_TAIL: begin
                    n_attempt = '0;
                    n_phase = PH_CMD55; n_frame = '0; n_poll = '0; n_arg = '0;
                end
                PH_CMD55_TAIL: begin
                    if (r_resp > R1_IDLE) res = RES_FAIL;
                    else begin
                        n_phase = PH_CMD41; n_frame = '0; n_poll = '0;
                        n_arg = r_hc ? ARG_HCS : '0;
                    end
                end
                PH_CMD41_TAIL: begin
                    if (r_resp == 8'd0) begin
                        n_phase = PH_CMD58; n_frame = '0; n_poll = '0; n_arg = '0;
                    end else n_phase = PH_RETRY_DELAY;
                end
                PH_RETRY_DELAY: begin
                    n_attempt = r_attempt + 12'd1;
                    if (n_attempt >= att_lim) res = RES_FAIL;
                    else begin
                        n_phase = PH_CMD55; n_frame = '0; n_poll = '0; n_arg = '0;
                    end
                end
                PH_OCR: begin
                    if (r_bc == '0) n_hc = rx[6];
                    n_bc = r_bc + 1'b1;
                    if (n_bc >= BC_W'(4)) n_phase = PH_CMD58_TAIL;
                end
                PH_CMD58_TAIL: begin
                    if (r_hc) res = RES_OK;
                    else begin
                        n_phase = PH_CMD16; n_frame = '0; n_poll = '0; n_arg = ARG_BLKLEN;
                    end
                end
                PH_CMD16_TAIL: res = (r_resp != 8'd0) ? RES_FAIL : RES_OK;
                PH_TOKEN: begin
                    if (rx != BYTE_FF) begin
                        if (rx == TOKEN_DATA) begin
                            n_bc = '0; n_phase = PH_DATA;
                        end else begin
                            n_read_resp = BYTE_FF; n_phase = PH_READ_FAIL_TAIL;
                        end
                    end else begin
                        n_poll = r_poll + 20'd1;
                        if (n_poll >= tok_lim) begin
                            n_read_resp = BYTE_FF; n_phase = PH_READ_FAIL_TAIL;
                        end
                    end
                end
                PH_DATA: begin
                    n_out.data_valid = 1'b1;
                    n_out.data_byte = rx;
                    n_out.data_index = r_bc[8:0];
                    n_bc = r_bc + 1'b1;
                    if (n_bc >= BC_W'(BLOCK_BYTES)) begin
                        n_bc = '0; n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_bc = r_bc + 1'b1;
                    if (n_bc >= BC_W'(2)) begin
                        n_bc = '0; n_phase = PH_READ_TAIL;
                    end
                end
                PH_READ_TAIL: begin
                    n_bc = r_bc + 1'b1;
                    if (n_bc >= BC_W'(3)) res = RES_OK;
                end
                default: res = RES_FAIL;
            endcase
        end

        if (res == RES_IGNORE) begin
            n_out = '0;
            n_out.action = ACT_IDLE;
        end else if (res != RES_ON) begin
            n_phase = PH_IDLE; n_frame = '0;
            n_out = '0;
            n_out.action = ACT_DONE;
            n_out.success = (res == RES_OK);
            n_out.last_r1 = n_read_resp;
        end else begin
            // result for the phase we move into
            n_out.slow_clock = !n_busy_op;
            if (n_phase == PH_PWR_DELAY) begin
                n_out.action = ACT_DELAY; n_out.delay_count = cfg.power_up_delay;
            end else if (n_phase == PH_RETRY_DELAY) begin
                n_out.action = ACT_DELAY; n_out.delay_count = cfg.retry_delay;
            end else begin
                n_out.action = ACT_XCHG;
                if (is_cmd(n_phase)) begin
                    n_out.cs_active = 1'b1;
                    case (n_frame)
                        4'd1: n_out.tx_byte = CMD_BASE | cmd_num(n_phase);
                        4'd2: n_out.tx_byte = n_arg[31:24];
                        4'd3: n_out.tx_byte = n_arg[23:16];
                        4'd4: n_out.tx_byte = n_arg[15:8];
                        4'd5: n_out.tx_byte = n_arg[7:0];
                        4'd6: n_out.tx_byte = (n_phase == PH_CMD0) ? CRC_CMD0 :
                                              (n_phase == PH_CMD8) ? CRC_CMD8 : CRC_OTHER;
                        default: n_out.tx_byte = BYTE_FF;
                    endcase
                end else begin
                    n_out.tx_byte = BYTE_FF;
                    n_out.cs_active = (n_phase == PH_CMD8_EXTRA || n_phase == PH_OCR ||
                                       n_phase == PH_TOKEN || n_phase == PH_DATA ||
                                       n_phase == PH_CRC);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_busy_op <= 1'b0; r_poll <= '0; r_attempt <= '0;
            r_frame <= '0; r_resp <= BYTE_FF; r_hc <= 1'b0; r_read_resp <= '0;
            r_arg <= '0; r_bc <= '0; r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase; r_busy_op <= n_busy_op; r_poll <= n_poll;
                r_attempt <= n_attempt; r_frame <= n_frame; r_resp <= n_resp;
                r_hc <= n_hc; r_read_resp <= n_read_resp; r_arg <= n_arg; r_bc <= n_bc;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_item = r_out;
endmodule

// File: rtl/sdspi_checker.sv
// port level checks of the sd card spi sequencer, bound to the top level
module sdspi_checker
    import sdspi_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // every accepted item yields one result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted item gave no result");

    // input stalls only while a result waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without waiting result");

    // data bytes only come with an exchange
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.data_valid |-> o_item.action == ACT_XCHG && o_item.cs_active)
        else $error("data byte outside exchange");
endmodule

bind sd_spi_init_and_block_read sdspi_checker u_sdspi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
);
